/* hw/rtl/lcdbg_pkg.sv */
// Shared types and constants for the LCD line timer / background renderer.
// No dependencies; the timer, renderer and top level refer to it by scoped names.
package lcdbg_pkg;

  // video memory geometry
  localparam int MEM_AW    = 13;
  localparam int MEM_DEPTH = 8192;
  localparam int BYTE_W    = 8;

  localparam int ACC_W  = 12;  // cycle accumulator
  localparam int SUM_W  = 13;  // accumulator plus one tick
  localparam int LINE_W = 8;
  localparam int GIDX_W = 5;
  localparam int GRP_W  = 16;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_HBLANK = 2'd0;
  localparam mode_t MODE_VBLANK = 2'd1;
  localparam mode_t MODE_SCAN   = 2'd2;
  localparam mode_t MODE_DRAW   = 2'd3;

  localparam logic [SUM_W-1:0] LEN_SCAN   = 13'd320;
  localparam logic [SUM_W-1:0] LEN_DRAW   = 13'd688;
  localparam logic [SUM_W-1:0] LEN_HBLANK = 13'd816;
  localparam logic [SUM_W-1:0] LEN_VLINE  = 13'd1824;

  localparam logic [MEM_AW-1:0] MAP_LOW  = 13'h1800;
  localparam logic [MEM_AW-1:0] MAP_HIGH = 13'h1C00;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DISPLAY_EN = 3'd0;
  localparam cfg_idx_t CFG_BG_EN      = 3'd1;
  localparam cfg_idx_t CFG_MAP_SEL    = 3'd2;
  localparam cfg_idx_t CFG_SCROLL_X   = 3'd3;
  localparam cfg_idx_t CFG_SCROLL_Y   = 3'd4;

  // timer next-state view
  typedef struct packed {
    mode_t             phase;
    logic [LINE_W-1:0] line;
    logic              pulse;
    logic              draw_done;
  } tmr_stat_t;

  // background fetch settings
  typedef struct packed {
    logic       map_sel;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
  } bg_cfg_t;

  // one finished pixel group from the renderer
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [GIDX_W-1:0] idx;
    logic [GRP_W-1:0]  word;
  } rgrp_t;

endpackage

/* hw/rtl/lcdbg_ram.sv */
// Generic single-port synchronous RAM, registered read, one access per cycle.
// No dependencies.
module lcdbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/lcdbg_timer.sv */
// Scan mode / line counter / cycle accumulator, one mode step per tick.
// Depends on lcdbg_pkg.
module lcdbg_timer #(
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_i,
  input  logic [7:0]                       cycles_i,
  output lcdbg_pkg::tmr_stat_t             nxt_o,
  output lcdbg_pkg::mode_t                 phase_o,
  output logic [lcdbg_pkg::LINE_W-1:0]     line_o
);

  lcdbg_pkg::mode_t                 phase_r, phase_nxt;
  logic [lcdbg_pkg::LINE_W-1:0]     line_r, line_nxt;
  logic [lcdbg_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [lcdbg_pkg::SUM_W-1:0]      sum, rem;
  logic [lcdbg_pkg::LINE_W-1:0]     line_inc;
  logic                             pulse, draw_done;

  // (line + 1) mod TOTAL_LINES, worked out at elaboration
  logic [lcdbg_pkg::LINE_W-1:0] wrap_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign wrap_tab[i] = 8'((i + 1) % TOTAL_LINES);
  end

  always_comb begin
    sum       = lcdbg_pkg::SUM_W'(acc_r) + lcdbg_pkg::SUM_W'(cycles_i);
    rem       = sum;
    phase_nxt = phase_r;
    line_nxt  = line_r;
    pulse     = 1'b0;
    draw_done = 1'b0;
    line_inc  = line_r + 8'd1;
    unique case (phase_r)
      lcdbg_pkg::MODE_SCAN: begin
        if (sum >= lcdbg_pkg::LEN_SCAN) begin
          rem       = sum - lcdbg_pkg::LEN_SCAN;
          phase_nxt = lcdbg_pkg::MODE_DRAW;
        end
      end
      lcdbg_pkg::MODE_DRAW: begin
        if (sum >= lcdbg_pkg::LEN_DRAW) begin
          rem       = sum - lcdbg_pkg::LEN_DRAW;
          phase_nxt = lcdbg_pkg::MODE_HBLANK;
          draw_done = 1'b1;
        end
      end
      lcdbg_pkg::MODE_HBLANK: begin
        if (sum >= lcdbg_pkg::LEN_HBLANK) begin
          rem      = sum - lcdbg_pkg::LEN_HBLANK;
          line_nxt = line_inc;
          if (line_inc >= 8'(VISIBLE_LINES)) begin
            phase_nxt = lcdbg_pkg::MODE_VBLANK;
            pulse     = 1'b1;
          end else begin
            phase_nxt = lcdbg_pkg::MODE_SCAN;
          end
        end
      end
      lcdbg_pkg::MODE_VBLANK: begin
        if (sum >= lcdbg_pkg::LEN_VLINE) begin
          rem      = sum - lcdbg_pkg::LEN_VLINE;
          line_nxt = wrap_tab[line_r];
          if (wrap_tab[line_r] == 8'd0) begin
            phase_nxt = lcdbg_pkg::MODE_SCAN;
          end
        end
      end
    endcase
    acc_nxt = rem[lcdbg_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcdbg_pkg::MODE_SCAN;
      line_r  <= '0;
      acc_r   <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign nxt_o.phase     = phase_nxt;
  assign nxt_o.line      = line_nxt;
  assign nxt_o.pulse     = pulse;
  assign nxt_o.draw_done = draw_done;
  assign phase_o         = phase_r;
  assign line_o          = line_r;

endmodule

/* hw/rtl/lcdbg_render.sv */
// Background scanline fetch: map, low and high pattern reads per pixel,
// packed into 8-pixel groups. Depends on lcdbg_pkg.
module lcdbg_render #(
  parameter int LINE_WIDTH = 160
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic                              take_i,
  input  lcdbg_pkg::bg_cfg_t                cfg_i,
  input  logic [lcdbg_pkg::LINE_W-1:0]      line_i,
  input  logic [lcdbg_pkg::BYTE_W-1:0]      rdata_i,
  output logic [lcdbg_pkg::MEM_AW-1:0]      rd_addr_o,
  output lcdbg_pkg::rgrp_t                  grp_o
);

  localparam int GROUPS = (LINE_WIDTH + 7) / 8;

  localparam logic [1:0] R_IDLE  = 2'd0;
  localparam logic [1:0] R_FETCH = 2'd1;
  localparam logic [1:0] R_HOLD  = 2'd2;

  logic [1:0]                        st_r, st_nxt;
  logic [7:0]                        x_r, x_nxt;      // pixel on the line
  logic [1:0]                        sub_r, sub_nxt;  // read step of a pixel
  logic [7:0]                        tile_r;
  logic                              lo_r;
  logic [lcdbg_pkg::GRP_W-1:0]       grp_r, grp_nxt;
  logic [7:0]                        sx, sy;
  logic [2:0]                        bsel;
  logic [1:0]                        pix;
  logic                              last_grp;

  assign sx       = cfg_i.scroll_x + x_r;
  assign sy       = cfg_i.scroll_y + line_i;
  assign bsel     = ~sx[2:0];
  assign last_grp = (x_r[7:3] == 5'(GROUPS - 1));

  // pixels past the line end read as zero
  assign pix = ({1'b0, x_r} >= 9'(LINE_WIDTH)) ? 2'b00 : {rdata_i[bsel], lo_r};

  always_comb begin
    unique case (sub_r)
      2'd0:    rd_addr_o = (cfg_i.map_sel ? lcdbg_pkg::MAP_HIGH : lcdbg_pkg::MAP_LOW)
                           + 13'({sy[7:3], sx[7:3]});
      2'd1:    rd_addr_o = {1'b0, rdata_i, sy[2:0], 1'b0};
      default: rd_addr_o = {1'b0, tile_r, sy[2:0], 1'b1};
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    x_nxt   = x_r;
    sub_nxt = sub_r;
    grp_nxt = grp_r;
    unique case (st_r)
      R_IDLE: begin
        if (start_i) begin
          st_nxt  = R_FETCH;
          x_nxt   = '0;
          sub_nxt = 2'd0;
        end
      end
      R_FETCH: begin
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          grp_nxt = {pix, grp_r[lcdbg_pkg::GRP_W-1:2]};
          if (x_r[2:0] == 3'd7) begin
            st_nxt = R_HOLD;
          end else begin
            x_nxt = x_r + 8'd1;
          end
        end
      end
      R_HOLD: begin
        if (take_i) begin
          if (last_grp) begin
            st_nxt = R_IDLE;
          end else begin
            st_nxt  = R_FETCH;
            x_nxt   = x_r + 8'd1;
            sub_nxt = 2'd0;
          end
        end
      end
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= R_IDLE;
      sub_r <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    grp_r <= grp_nxt;
    if (st_r == R_FETCH && sub_r == 2'd1) begin
      tile_r <= rdata_i;
    end
    if (st_r == R_FETCH && sub_r == 2'd2) begin
      lo_r <= rdata_i[bsel];
    end
  end

  assign grp_o.valid = (st_r == R_HOLD);
  assign grp_o.last  = last_grp;
  assign grp_o.idx   = x_r[7:3];
  assign grp_o.word  = grp_r;

endmodule

/* hw/rtl/lcd_line_timer_bg_renderer_unit.sv */
// LCD line timer and background renderer. Ticks (op 0), video memory writes (op 1).
// A write or a tick without pixels is registered on accept; its word is loaded once the output is free.
// A tick that ends drawing with display and background on gives 20 groups of 8 pixels, each pixel
// fetched by map, low and high reads in turn on one port, each group held until it is loaded.
// Throughput: one item at a time; next item taken once the last word is loaded.
// Reset: synchronous; then a clearing pass zeroes all 8192 memory bytes with in_tready low.
module lcd_line_timer_bg_renderer_unit #(
  parameter int LINE_WIDTH    = 160,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cycles[7:0], mem_addr[20:8], mem_data[28:21], zero
  input  logic        in_tuser,   // op: 0 tick, 1 video memory write
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // scan_mode[1:0], line_number[9:2], vblank_pulse[10],
                                  // pixel_group[26:11], group_index[31:27]
  output logic        out_tuser,  // has_pixels
  output logic        out_tlast,  // last
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // control states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RENDER = 3'd3;

  logic [2:0] st_r, st_nxt;

  // config registers
  logic disp_en_r, bg_en_r, map_sel_r;
  logic [7:0] scroll_x_r, scroll_y_r;

  // accepted item
  logic                                op_r;
  logic [7:0]                          cycles_r;
  logic [lcdbg_pkg::MEM_AW-1:0]        waddr_r;
  logic [lcdbg_pkg::BYTE_W-1:0]        wdata_r;

  // clearing pass
  logic [lcdbg_pkg::MEM_AW-1:0]        clr_cnt_r;

  // memory port
  logic                                ram_we;
  logic [lcdbg_pkg::MEM_AW-1:0]        ram_addr;
  logic [lcdbg_pkg::BYTE_W-1:0]        ram_wdata, ram_rdata;

  // timer / renderer
  logic                                tmr_step;
  lcdbg_pkg::tmr_stat_t                tmr_nxt;
  lcdbg_pkg::mode_t                    phase;
  logic [lcdbg_pkg::LINE_W-1:0]        line;
  lcdbg_pkg::bg_cfg_t                  bg_cfg;
  lcdbg_pkg::rgrp_t                    grp;
  logic [lcdbg_pkg::MEM_AW-1:0]        rnd_addr;
  logic                                rnd_start, rnd_take;

  // output register
  logic                                out_vld_r;
  lcdbg_pkg::mode_t                    o_mode_r, o_mode_nxt;
  logic [lcdbg_pkg::LINE_W-1:0]        o_line_r, o_line_nxt;
  logic                                o_pulse_r, o_pulse_nxt;
  logic                                o_has_r, o_has_nxt;
  logic [lcdbg_pkg::GRP_W-1:0]         o_grp_r, o_grp_nxt;
  logic [lcdbg_pkg::GIDX_W-1:0]        o_gidx_r, o_gidx_nxt;
  logic                                o_last_r, o_last_nxt;
  logic                                o_load;
  logic                                slot_free;

  assign slot_free = !out_vld_r || out_tready;
  assign in_tready = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign bg_cfg.map_sel  = map_sel_r;
  assign bg_cfg.scroll_x = scroll_x_r;
  assign bg_cfg.scroll_y = scroll_y_r;

  // ---------------------------------------------------------------------------
  // Control: clear, accept, execute one item, stream pixel groups
  // ---------------------------------------------------------------------------
  always_comb begin
    st_nxt      = st_r;
    tmr_step    = 1'b0;
    rnd_start   = 1'b0;
    rnd_take    = 1'b0;
    o_load      = 1'b0;
    // plain status word by default: current mode and line, no pixels
    o_mode_nxt  = phase;
    o_line_nxt  = line;
    o_pulse_nxt = 1'b0;
    o_has_nxt   = 1'b0;
    o_grp_nxt   = '0;
    o_gidx_nxt  = '0;
    o_last_nxt  = 1'b1;
    unique case (st_r)
      S_CLEAR: begin
        if (clr_cnt_r == lcdbg_pkg::MEM_AW'(lcdbg_pkg::MEM_DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          if (op_r || !disp_en_r) begin
            o_load = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            tmr_step = 1'b1;
            if (tmr_nxt.draw_done && bg_en_r) begin
              rnd_start = 1'b1;
              st_nxt    = S_RENDER;
            end else begin
              o_load      = 1'b1;
              o_mode_nxt  = tmr_nxt.phase;
              o_line_nxt  = tmr_nxt.line;
              o_pulse_nxt = tmr_nxt.pulse;
              st_nxt      = S_IDLE;
            end
          end
        end
      end
      S_RENDER: begin
        // phase is already hblank here; line is unchanged by end of drawing
        if (grp.valid && slot_free) begin
          o_load     = 1'b1;
          rnd_take   = 1'b1;
          o_has_nxt  = 1'b1;
          o_grp_nxt  = grp.word;
          o_gidx_nxt = grp.idx;
          o_last_nxt = grp.last;
          if (grp.last) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // memory port: clearing sweep, then item writes, else renderer reads
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rnd_addr;
    ram_wdata = wdata_r;
    if (st_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (st_r == S_EXEC && op_r && slot_free) begin
      ram_we   = 1'b1;
      ram_addr = waddr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CLEAR;
      clr_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
      disp_en_r  <= 1'b1;
      bg_en_r    <= 1'b1;
      map_sel_r  <= 1'b0;
      scroll_x_r <= '0;
      scroll_y_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + lcdbg_pkg::MEM_AW'(1);
      end
      if (o_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          lcdbg_pkg::CFG_DISPLAY_EN: disp_en_r  <= cfg_data[0];
          lcdbg_pkg::CFG_BG_EN:      bg_en_r    <= cfg_data[0];
          lcdbg_pkg::CFG_MAP_SEL:    map_sel_r  <= cfg_data[0];
          lcdbg_pkg::CFG_SCROLL_X:   scroll_x_r <= cfg_data;
          lcdbg_pkg::CFG_SCROLL_Y:   scroll_y_r <= cfg_data;
          default: ;  // unknown index: dropped
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= in_tuser;
      cycles_r <= in_tdata[7:0];
      waddr_r  <= in_tdata[20:8];
      wdata_r  <= in_tdata[28:21];
    end
    if (o_load) begin
      o_mode_r  <= o_mode_nxt;
      o_line_r  <= o_line_nxt;
      o_pulse_r <= o_pulse_nxt;
      o_has_r   <= o_has_nxt;
      o_grp_r   <= o_grp_nxt;
      o_gidx_r  <= o_gidx_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {o_gidx_r, o_grp_r, o_pulse_r, o_line_r, o_mode_r};
  assign out_tuser  = o_has_r;
  assign out_tlast  = o_last_r;

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  lcdbg_ram #(
    .WIDTH (lcdbg_pkg::BYTE_W),
    .DEPTH (lcdbg_pkg::MEM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lcdbg_timer #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (tmr_step),
    .cycles_i (cycles_r),
    .nxt_o    (tmr_nxt),
    .phase_o  (phase),
    .line_o   (line)
  );

  lcdbg_render #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_render (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (rnd_start),
    .take_i    (rnd_take),
    .cfg_i     (bg_cfg),
    .line_i    (line),
    .rdata_i   (ram_rdata),
    .rd_addr_o (rnd_addr),
    .grp_o     (grp)
  );

endmodule

/* hw/rtl/lcdbg_checker.sv */
// Port-level checks for lcd_line_timer_bg_renderer_unit, bound to the top level.
// Depends only on the top level's ports.
module lcdbg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // clearing pass holds off input right after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("input taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while busy");

  // pixel words never carry the vblank pulse
  a_pix_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tdata[10])
    else $error("vblank pulse on pixel word");

  // status words are single, with empty pixel fields
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata[31:11] == 21'd0))
    else $error("malformed status word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind lcd_line_timer_bg_renderer_unit lcdbg_checker u_lcdbg_checker (.*);
